/* rtl/core/w2s_pkg.sv */
// w2s_pkg: shared types and constants of the world-to-screen projection block
// no dependencies; imported by the interfaces and every module of the block but w2s_fifo

package w2s_pkg;

  localparam int COEF_W     = 32;
  localparam int COEF_IDX_W = 4;
  localparam int NUM_COEFS  = 12;
  localparam int SIZE_W     = 14;
  localparam int STATUS_W   = 2;
  localparam int QUOT_BITS  = 40;   // quotient saturates at magnitude 2^40
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  // offsets of the three rows in the coefficient store
  localparam int ROW_RIGHT = 0;
  localparam int ROW_UP    = 4;
  localparam int ROW_DEPTH = 8;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KEEP   = 2'd2;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1080);

  typedef enum logic [STATUS_W-1:0] {
    ST_VISIBLE = 2'd0,
    ST_OFF     = 2'd1,
    ST_ZERO    = 2'd2,
    ST_BEHIND  = 2'd3
  } status_e;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              keep;
  } cfg_t;

endpackage

/* rtl/core/w2s_if.sv */
// w2s_in_if / w2s_out_if: valid-ready channels for input items and results
// depends on w2s_pkg for field widths

interface w2s_in_if
  import w2s_pkg::*;
  ();
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [COEF_IDX_W-1:0]        coef_index;
  logic signed [COEF_W-1:0]     coef_value;
  logic signed [COEF_W-1:0]     point_x;
  logic signed [COEF_W-1:0]     point_y;
  logic signed [COEF_W-1:0]     point_z;

  modport source (output valid, op, coef_index, coef_value, point_x, point_y, point_z,
                  input ready);
  modport sink   (input valid, op, coef_index, coef_value, point_x, point_y, point_z,
                  output ready);
endinterface

interface w2s_out_if
  import w2s_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] screen_x;
  logic signed [COEF_W-1:0] screen_y;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, screen_x, screen_y, status, input ready);
  modport sink   (input valid, screen_x, screen_y, status, output ready);
endinterface

/* rtl/core/world_to_screen_projection.sv */
// world_to_screen_projection: top level, apb registers, front, queue and back
// depends on w2s_pkg, w2s_if, w2s_front, w2s_fifo, w2s_back
//
//   port     | dir | handshake         | carries
//   item_i   | in  | valid/ready       | op, coef_index, coef_value, point_x/y/z
//   res_o    | out | valid/ready       | screen_x, screen_y, status
//   apb      | in  | psel/penable      | screen_width, screen_height, keep_behind_camera
//
// one item per cycle unless the queue or output stalls; a projection result passes through
// two front stages, the queue, 43 divider stages and two scaling stages
// loads finish in the cycle they are accepted and give no result
// reset clears the coefficient store, the registers to their defaults and all valids
// a stalled output freezes the back part; the four-entry queue lets the front keep going until it is full

module world_to_screen_projection
  import w2s_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  w2s_in_if.sink             item_i,
  w2s_out_if.source          res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int SUM_W = 2 * COEF_W + 2 - FRACTION_BITS;
  localparam int ENT_W = 3 * SUM_W + STATUS_W;

  cfg_t cfg_q;

  logic             push, pop, full, empty;
  logic [SUM_W-1:0] f_w, f_x, f_y;
  status_e          f_st;
  logic [ENT_W-1:0] ent_in, ent_out;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= WIDTH_RESET;
      cfg_q.height <= HEIGHT_RESET;
      cfg_q.keep   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WIDTH:  cfg_q.width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: cfg_q.height <= pwdata[SIZE_W-1:0];
        REG_KEEP:   cfg_q.keep   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = PDATA_W'(cfg_q.width);
      REG_HEIGHT: prdata = PDATA_W'(cfg_q.height);
      REG_KEEP:   prdata = PDATA_W'(cfg_q.keep);
      default:    prdata = '0;
    endcase
  end

  w2s_front #(.FRAC(FRACTION_BITS), .SUM_W(SUM_W)) u_front (
    .clk_i, .rst_ni, .item_i, .keep_i(cfg_q.keep), .full_i(full),
    .push_o(push), .w_o(f_w), .x_o(f_x), .y_o(f_y), .st_o(f_st)
  );

  assign ent_in = {f_w, f_x, f_y, f_st};

  w2s_fifo #(.WIDTH(ENT_W), .DEPTH(4)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(ent_in), .pop_i(pop),
    .data_o(ent_out), .full_o(full), .empty_o(empty)
  );

  w2s_back #(.FRAC(FRACTION_BITS), .SUM_W(SUM_W)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .empty_i(empty),
    .w_i(ent_out[ENT_W-1 -: SUM_W]),
    .x_i(ent_out[ENT_W-1-SUM_W -: SUM_W]),
    .y_i(ent_out[STATUS_W +: SUM_W]),
    .st_i(status_e'(ent_out[STATUS_W-1:0])),
    .pop_o(pop), .res_o
  );

endmodule

/* rtl/core/w2s_front.sv */
// w2s_front: accepts items, keeps the coefficient store, forms w, x, y and classifies
// depends on w2s_pkg and w2s_in_if

module w2s_front
  import w2s_pkg::*;
#(
  parameter int FRAC  = 16,
  parameter int SUM_W = 50
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  w2s_in_if.sink                  item_i,
  input  logic                    keep_i,
  input  logic                    full_i,
  output logic                    push_o,
  output logic [SUM_W-1:0]        w_o,
  output logic [SUM_W-1:0]        x_o,
  output logic [SUM_W-1:0]        y_o,
  output status_e                 st_o
);

  localparam int PW = 2 * COEF_W - FRAC;
  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << FRAC;

  logic signed [COEF_W-1:0]   coef_q [NUM_COEFS];
  logic signed [COEF_W-1:0]   pt [3];
  logic signed [2*COEF_W-1:0] prod [9];

  logic                       a_v_q, b_v_q;
  logic signed [PW-1:0]       a_prod_q [9];
  logic signed [COEF_W-1:0]   a_off_q [3];
  logic                       a_zero_q;

  logic signed [SUM_W-1:0]    sum [3];
  logic [SUM_W-1:0]           b_w_q, b_x_q, b_y_q;
  status_e                    b_st_q, st_d;

  logic accept, a_ready, b_ready;

  assign b_ready      = !b_v_q || !full_i;
  assign a_ready      = !a_v_q || b_ready;
  assign item_i.ready = a_ready;
  assign accept       = item_i.valid && a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFS; i++) coef_q[i] <= '0;
    end else if (accept && item_i.op == OP_LOAD &&
                 item_i.coef_index < COEF_IDX_W'(NUM_COEFS)) begin
      coef_q[item_i.coef_index] <= item_i.coef_value;
    end
  end

  assign pt[0] = item_i.point_x;
  assign pt[1] = item_i.point_y;
  assign pt[2] = item_i.point_z;

  // row r, column c: coefficient r*4+c times coordinate c
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r*3+c] = coef_q[r*4+c] * pt[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_ready) begin
      a_v_q <= accept && item_i.op == OP_PROJECT;
    end
  end

  // upper bits of each product are the floor shift
  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      for (int i = 0; i < 9; i++) a_prod_q[i] <= prod[i][2*COEF_W-1:FRAC];
      a_off_q[0] <= coef_q[ROW_RIGHT+3];
      a_off_q[1] <= coef_q[ROW_UP+3];
      a_off_q[2] <= coef_q[ROW_DEPTH+3];
      a_zero_q   <= item_i.point_x == '0 && item_i.point_y == '0 && item_i.point_z == '0;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SUM_W'(a_prod_q[r*3]) + SUM_W'(a_prod_q[r*3+1]) +
               SUM_W'(a_prod_q[r*3+2]) + SUM_W'(a_off_q[r]);
    end
    if (a_zero_q) begin
      st_d = ST_ZERO;
    end else if (sum[2] < ONE) begin
      st_d = keep_i ? ST_OFF : ST_BEHIND;
    end else begin
      st_d = ST_VISIBLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (b_ready) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready) begin
      b_x_q  <= sum[0];
      b_y_q  <= sum[1];
      b_w_q  <= sum[2];
      b_st_q <= st_d;
    end
  end

  assign push_o = b_v_q && !full_i;
  assign w_o    = b_w_q;
  assign x_o    = b_x_q;
  assign y_o    = b_y_q;
  assign st_o   = b_st_q;

endmodule

/* rtl/core/w2s_fifo.sv */
// w2s_fifo: short register queue between the front and the back part
// depends on nothing but its parameters

module w2s_fifo #(
  parameter int WIDTH = 152,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

/* rtl/core/w2s_div.sv */
// w2s_div: pipelined restoring divider, one quotient bit per stage, saturating
// depends on w2s_pkg

module w2s_div
  import w2s_pkg::*;
#(
  parameter int FRAC  = 16,
  parameter int SUM_W = 50
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [SUM_W-1:0]              num_i,
  input  logic [SUM_W-1:0]              den_i,
  output logic signed [QUOT_BITS+1:0]   quot_o
);

  localparam int QB = QUOT_BITS + 1;          // quotient bits before clamping
  localparam int QW = QUOT_BITS + 2;          // signed result width
  localparam int NW = SUM_W + FRAC;           // scaled dividend width
  localparam int CW = SUM_W + QB;
  localparam logic [QB-1:0] LIM = QB'(1) << QUOT_BITS;

  logic [SUM_W-1:0] an, ad;
  logic [NW-1:0]    n_scaled;
  logic             ovf;

  logic [NW-1:0]    n_q   [QB+1];
  logic [SUM_W-1:0] ad_q  [QB+1];
  logic [SUM_W-1:0] r_q   [QB+1];
  logic [QB-1:0]    qb_q  [QB+1];
  logic             neg_q [QB+1];
  logic             nz_q  [QB+1];
  logic             sat_q [QB+1];

  logic [QB-1:0]    mag;
  logic signed [QW-1:0] quot_q;

  assign an       = num_i[SUM_W-1] ? SUM_W'(-num_i) : num_i;
  assign ad       = den_i[SUM_W-1] ? SUM_W'(-den_i) : den_i;
  assign n_scaled = {an, FRAC'(0)};
  // quotient would need more than QB bits
  assign ovf      = CW'(n_scaled) >= {ad, QB'(0)};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= n_scaled;
      ad_q[0]  <= ad;
      r_q[0]   <= SUM_W'(n_scaled[NW-1:QB]);
      qb_q[0]  <= '0;
      neg_q[0] <= num_i[SUM_W-1] ^ den_i[SUM_W-1];
      nz_q[0]  <= an != '0;
      sat_q[0] <= ad == '0 || ovf;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [SUM_W:0] r_ext, diff;
    logic           ge;

    always_comb begin
      r_ext = {r_q[k], n_q[k][QB-1-k]};
      diff  = r_ext - {1'b0, ad_q[k]};
      ge    = !diff[SUM_W];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1]   <= n_q[k];
        ad_q[k+1]  <= ad_q[k];
        r_q[k+1]   <= ge ? diff[SUM_W-1:0] : r_ext[SUM_W-1:0];
        qb_q[k+1]  <= qb_q[k] | (QB'(ge) << (QB - 1 - k));
        neg_q[k+1] <= neg_q[k];
        nz_q[k+1]  <= nz_q[k];
        sat_q[k+1] <= sat_q[k];
      end
    end
  end

  assign mag = (sat_q[QB] || qb_q[QB] > LIM) ? LIM : qb_q[QB];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!nz_q[QB])      quot_q <= '0;
      else if (neg_q[QB]) quot_q <= -$signed(QW'(mag));
      else                quot_q <= $signed(QW'(mag));
    end
  end

  assign quot_o = quot_q;

endmodule

/* rtl/core/w2s_back.sv */
// w2s_back: divides x and y by w, scales to the viewport, saturates and grades
// depends on w2s_pkg, w2s_out_if and w2s_div

module w2s_back
  import w2s_pkg::*;
#(
  parameter int FRAC  = 16,
  parameter int SUM_W = 50
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             empty_i,
  input  logic [SUM_W-1:0] w_i,
  input  logic [SUM_W-1:0] x_i,
  input  logic [SUM_W-1:0] y_i,
  input  status_e          st_i,
  output logic             pop_o,
  w2s_out_if.source        res_o
);

  localparam int QW = QUOT_BITS + 2;
  localparam int DL = QUOT_BITS + 3;       // divider latency in stages
  localparam int MW = QW + SIZE_W + 2;     // size times (one +/- quotient)
  localparam int SW = MW - 1;
  localparam logic signed [QW:0] ONE = (QW + 1)'(1) << FRAC;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-COEF_W+1){1'b0}}, {(COEF_W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-COEF_W+1){1'b1}}, {(COEF_W-1){1'b0}}};

  logic en;
  logic signed [QW-1:0] qx, qy;
  logic                 v_q  [DL];
  status_e              st_q [DL];

  logic signed [QW:0]   ox, oy;
  logic signed [MW-1:0] mx_q, my_q;
  logic                 m_v_q;
  status_e              m_st_q;

  logic signed [SW-1:0] sx, sy, lim_x, lim_y;
  logic                 off;
  logic                 out_v_q;
  logic signed [COEF_W-1:0] out_x_q, out_y_q;
  status_e              out_st_q;

  // the whole back part moves unless a result is held at the output
  assign en    = !out_v_q || res_o.ready;
  assign pop_o = en && !empty_i;

  w2s_div #(.FRAC(FRAC), .SUM_W(SUM_W)) u_div_x (
    .clk_i, .en_i(en), .num_i(x_i), .den_i(w_i), .quot_o(qx)
  );

  w2s_div #(.FRAC(FRAC), .SUM_W(SUM_W)) u_div_y (
    .clk_i, .en_i(en), .num_i(y_i), .den_i(w_i), .quot_o(qy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DL; i++) v_q[i] <= 1'b0;
      m_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= pop_o;
      for (int i = 1; i < DL; i++) v_q[i] <= v_q[i-1];
      m_v_q   <= v_q[DL-1];
      out_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= st_i;
      for (int i = 1; i < DL; i++) st_q[i] <= st_q[i-1];
    end
  end

  assign ox = ONE + (QW + 1)'(qx);
  assign oy = ONE - (QW + 1)'(qy);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q   <= $signed({1'b0, cfg_i.width}) * ox;
      my_q   <= $signed({1'b0, cfg_i.height}) * oy;
      m_st_q <= st_q[DL-1];
    end
  end

  always_comb begin
    sx    = mx_q[MW-1:1];
    sy    = my_q[MW-1:1];
    lim_x = $signed(SW'(cfg_i.width) << FRAC);
    lim_y = $signed(SW'(cfg_i.height) << FRAC);
    off   = sx <= 0 || sy <= 0 || sx >= lim_x || sy >= lim_y;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (m_st_q == ST_ZERO || m_st_q == ST_BEHIND) begin
        out_x_q  <= '0;
        out_y_q  <= '0;
        out_st_q <= m_st_q;
      end else begin
        out_x_q  <= sx > SAT_HI ? SAT_HI[COEF_W-1:0] :
                    sx < SAT_LO ? SAT_LO[COEF_W-1:0] : sx[COEF_W-1:0];
        out_y_q  <= sy > SAT_HI ? SAT_HI[COEF_W-1:0] :
                    sy < SAT_LO ? SAT_LO[COEF_W-1:0] : sy[COEF_W-1:0];
        out_st_q <= (m_st_q == ST_OFF || off) ? ST_OFF : ST_VISIBLE;
      end
    end
  end

  assign res_o.valid    = out_v_q;
  assign res_o.screen_x = out_x_q;
  assign res_o.screen_y = out_y_q;
  assign res_o.status   = out_st_q;

endmodule

/* rtl/core/w2s_checker.sv */
// w2s_checker: port-level checks of the projection block, bound to the top level
// depends on w2s_pkg

module w2s_checker
  import w2s_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [COEF_W-1:0] screen_x,
  input logic signed [COEF_W-1:0] screen_y,
  input logic [STATUS_W-1:0]      status
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y)
                                && $stable(status))
    else $error("result changed while stalled");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status == ST_ZERO || status == ST_BEHIND) |-> screen_x == '0 && screen_y == '0)
    else $error("rejected item has nonzero position");

  a_visible_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == ST_VISIBLE |-> screen_x > 0 && screen_y > 0)
    else $error("visible item outside positive quadrant");

  // reset clears the output valid by the following edge
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind world_to_screen_projection w2s_checker u_w2s_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .screen_x  (res_o.screen_x),
  .screen_y  (res_o.screen_y),
  .status    (res_o.status)
);
